### hw/rtl/jss3d_pkg.sv
package jss3d_pkg;

    localparam int MAX_X_DEF = 256;
    localparam int MAX_Y_DEF = 64;
    localparam int MAX_Z_DEF = 64;

    localparam int VAL_W      = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [VAL_W-1:0] ALPHA_RST    = 32'd65536;
    localparam logic [VAL_W-1:0] INV_BETA_RST = 32'd10923;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X   = 3'd0,
        REG_SIZE_Y   = 3'd1,
        REG_SIZE_Z   = 3'd2,
        REG_ALPHA    = 3'd3,
        REG_INV_BETA = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EMIT
    } state_t;

endpackage

### hw/rtl/jacobi_stencil_sweep_3d_core.sv
// One Jacobi sweep of a 7-point stencil over a 3-D grid, streamed in raster order
// (z fastest, then y, then x). Each input transfer carries an old-field voxel and
// a source voxel in s_tdata; s_tuser marks a flush item that pads the stream after
// the last grid voxel. Each result transfer carries the new voxel value and its
// coordinates in m_tdata, and m_tlast marks the final voxel of the sweep.
// Results lag the input by one x-plane (size_y*size_z items), so size_y*size_z
// flush items drain the last plane. An item that produces a result goes, from its
// transfer to the result register, through six reads of the single old-field
// window memory port, a drain state for the read latency, and the arithmetic
// states (sum, two partial products of the final scale, saturation); the source
// product overlaps the reads. Input is held off until the state machine is idle
// again, so the block does not take a new item before the last one is through.
// Items that produce no result do not hold off input. A new item is taken while a
// finished result still waits; if the receiver stalls, the next result holds in
// the final stage and input stops. Writing a size register restarts the sweep
// and blocks input while a settle counter runs down. Reset clears the counters,
// sets all sizes to one, restores alpha and inv_beta; memories are not cleared.
module jacobi_stencil_sweep_3d_core #(
    parameter int MAX_X = jss3d_pkg::MAX_X_DEF,
    parameter int MAX_Y = jss3d_pkg::MAX_Y_DEF,
    parameter int MAX_Z = jss3d_pkg::MAX_Z_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // old_value, source_value
    input  logic [jss3d_pkg::S_TDATA_W-1:0]     s_tdata,
    // flush
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_value, out_x, out_y, out_z, zero fill
    output logic [jss3d_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [jss3d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jss3d_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import jss3d_pkg::*;

    localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int SXW = $clog2(MAX_X + 1);
    localparam int SYW = $clog2(MAX_Y + 1);
    localparam int SZW = $clog2(MAX_Z + 1);
    localparam int PLW = $clog2(MAX_Y * MAX_Z + 1);
    localparam longint TOT_MAX = longint'(MAX_X) * longint'(MAX_Y) * longint'(MAX_Z);
    localparam int CW  = $clog2(TOT_MAX + 1);
    localparam int WAW = $clog2(2 * MAX_Y * MAX_Z + 1);
    localparam int SAW = (MAX_Y * MAX_Z > 0) ? $clog2(MAX_Y * MAX_Z + 1) : 1;
    localparam int WIN_DEPTH = 1 << WAW;
    localparam int SRC_DEPTH = 1 << SAW;

    logic [SXW-1:0] sx_reg;
    logic [SYW-1:0] sy_reg;
    logic [SZW-1:0] sz_reg;
    logic signed [VAL_W-1:0] alpha_reg;
    logic signed [VAL_W-1:0] ib_reg;
    logic [PLW-1:0] plane_reg;
    logic [CW-1:0]  total_reg;
    logic [1:0]     settle_reg;
    logic [SYW+SZW-1:0] plane_full;
    logic [SXW+PLW-1:0] total_full;

    logic [CW-1:0] in_cnt_reg;
    logic [CW-1:0] m_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [ZW-1:0] z_reg;

    state_t state_reg, state_next;
    logic [2:0] k_reg;
    logic       rd_pend_reg;

    logic signed [34:0] sum_reg;
    logic signed [63:0] prod_reg;
    logic signed [48:0] t_reg;
    logic signed [56:0] pl_reg;
    logic signed [56:0] ph_reg;

    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_val_reg;
    logic [7:0]          out_x_reg;
    logic [5:0]          out_y_reg;
    logic [5:0]          out_z_reg;
    logic                out_last_reg;

    logic           acc, in_grid, do_write, take, emits, size_wr, out_free;
    logic [WAW-1:0] win_raddr, mw, plw, szw;
    logic [VAL_W-1:0] win_rdata, src_rdata;
    logic           x_hi, x_lo, y_hi, y_lo, z_hi, z_lo;
    logic signed [VAL_W-1:0] src_s;
    logic signed [24:0] tl_s, th_s;
    logic signed [80:0] p_full;
    logic [64:0]        q;
    logic [VAL_W-1:0]   q_sat;
    logic [8:0]         cx;
    logic [6:0]         cy, cz;

    assign acc      = s_tvalid && s_tready;
    assign in_grid  = in_cnt_reg < total_reg;
    assign do_write = acc && in_grid && !s_tuser;
    assign take     = acc && !(in_grid && s_tuser);
    assign emits    = take && (in_cnt_reg >= CW'(plane_reg));
    assign out_free = !out_valid_reg || m_tready;
    assign size_wr  = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                 cfg_index == REG_SIZE_Z);

    assign plane_full = sy_reg * sz_reg;
    assign total_full = sx_reg * plane_reg;

    assign mw  = WAW'(m_reg);
    assign plw = WAW'(plane_reg);
    assign szw = WAW'(sz_reg);
    assign x_hi = (SXW'(x_reg) + SXW'(1)) != sx_reg;
    assign x_lo = x_reg != '0;
    assign y_hi = (SYW'(y_reg) + SYW'(1)) != sy_reg;
    assign y_lo = y_reg != '0;
    assign z_hi = (SZW'(z_reg) + SZW'(1)) != sz_reg;
    assign z_lo = z_reg != '0;

    jss3d_ram #(.WIDTH(VAL_W), .DEPTH(WIN_DEPTH)) u_win_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (WAW'(in_cnt_reg)),
        .wdata (s_tdata[VAL_W-1:0]),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    jss3d_ram #(.WIDTH(VAL_W), .DEPTH(SRC_DEPTH)) u_src_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (SAW'(in_cnt_reg)),
        .wdata (s_tdata[2*VAL_W-1:VAL_W]),
        .raddr (SAW'(m_reg)),
        .rdata (src_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (emits) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (k_reg == 3'd5) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE) && (settle_reg == 2'd0);
        win_raddr = mw;
        case (k_reg)
            3'd0:    win_raddr = x_hi ? mw + plw : mw;
            3'd1:    win_raddr = x_lo ? mw - plw : mw;
            3'd2:    win_raddr = y_hi ? mw + szw : mw;
            3'd3:    win_raddr = y_lo ? mw - szw : mw;
            3'd4:    win_raddr = z_hi ? mw + WAW'(1) : mw;
            3'd5:    win_raddr = z_lo ? mw - WAW'(1) : mw;
            default: win_raddr = mw;
        endcase
    end

    assign src_s  = src_rdata;
    assign tl_s   = {1'b0, t_reg[23:0]};
    assign th_s   = t_reg[48:24];
    assign p_full = {ph_reg, 24'b0} + {{24{pl_reg[56]}}, pl_reg};
    assign q      = p_full[80:16];
    assign q_sat  = ((&q[64:31]) || !(|q[64:31])) ? q[31:0] :
                    (q[64] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign cx = cfg_wdata[8:0];
    assign cy = cfg_wdata[6:0];
    assign cz = cfg_wdata[6:0];

    always_ff @(posedge aclk) begin
        plane_reg <= PLW'(plane_full);
        total_reg <= CW'(total_full);
        if (rd_pend_reg) begin
            sum_reg <= sum_reg + {{3{win_rdata[31]}}, win_rdata};
        end
        if (acc) begin
            sum_reg <= '0;
        end
        if (state_reg == ST_READ && k_reg == 3'd1) begin
            prod_reg <= alpha_reg * src_s;
        end
        if (state_reg == ST_SUM) begin
            t_reg <= {{14{sum_reg[34]}}, sum_reg} + {prod_reg[63], prod_reg[63:16]};
        end
        if (state_reg == ST_MUL_LO) begin
            pl_reg <= tl_s * ib_reg;
        end
        if (state_reg == ST_MUL_HI) begin
            ph_reg <= th_s * ib_reg;
        end
        if (state_reg == ST_EMIT && out_free) begin
            out_val_reg  <= q_sat;
            out_x_reg    <= 8'(x_reg);
            out_y_reg    <= 6'(y_reg);
            out_z_reg    <= 6'(z_reg);
            out_last_reg <= (m_reg + CW'(1)) == total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg        <= SXW'(1);
            sy_reg        <= SYW'(1);
            sz_reg        <= SZW'(1);
            alpha_reg     <= ALPHA_RST;
            ib_reg        <= INV_BETA_RST;
            settle_reg    <= 2'd2;
            in_cnt_reg    <= '0;
            m_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
            if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (state_reg == ST_READ) begin
                k_reg <= k_reg + 3'd1;
            end else begin
                k_reg <= '0;
            end
            if (take) begin
                in_cnt_reg <= in_cnt_reg + CW'(1);
            end
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
                if ((m_reg + CW'(1)) >= total_reg) begin
                    in_cnt_reg <= '0;
                    m_reg      <= '0;
                    x_reg      <= '0;
                    y_reg      <= '0;
                    z_reg      <= '0;
                end else begin
                    m_reg <= m_reg + CW'(1);
                    if (z_hi) begin
                        z_reg <= z_reg + ZW'(1);
                    end else begin
                        z_reg <= '0;
                        if (y_hi) begin
                            y_reg <= y_reg + YW'(1);
                        end else begin
                            y_reg <= '0;
                            x_reg <= x_reg + XW'(1);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SIZE_X: begin
                        if (cx == 9'd0) begin
                            sx_reg <= SXW'(1);
                        end else if (32'(cx) > 32'(MAX_X)) begin
                            sx_reg <= SXW'(MAX_X);
                        end else begin
                            sx_reg <= SXW'(cx);
                        end
                    end
                    REG_SIZE_Y: begin
                        if (cy == 7'd0) begin
                            sy_reg <= SYW'(1);
                        end else if (32'(cy) > 32'(MAX_Y)) begin
                            sy_reg <= SYW'(MAX_Y);
                        end else begin
                            sy_reg <= SYW'(cy);
                        end
                    end
                    REG_SIZE_Z: begin
                        if (cz == 7'd0) begin
                            sz_reg <= SZW'(1);
                        end else if (32'(cz) > 32'(MAX_Z)) begin
                            sz_reg <= SZW'(MAX_Z);
                        end else begin
                            sz_reg <= SZW'(cz);
                        end
                    end
                    REG_ALPHA:    alpha_reg <= cfg_wdata;
                    REG_INV_BETA: ib_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (size_wr) begin
                settle_reg <= 2'd2;
                in_cnt_reg <= '0;
                m_reg      <= '0;
                x_reg      <= '0;
                y_reg      <= '0;
                z_reg      <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_z_reg, out_y_reg, out_x_reg, out_val_reg};

endmodule

### hw/rtl/jss3d_ram.sv
module jss3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### test/jacobi_stencil_sweep_3d_core_test.sv
module jacobi_stencil_sweep_3d_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jss3d_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_Y_DEF * MAX_Z_DEF + 1;
    localparam int SRC_DEPTH = MAX_Y_DEF * MAX_Z_DEF + 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD = 300;
    localparam int ITEM_GOAL = 1400;

    typedef struct {
        logic [31:0] new_value;
        logic [7:0]  vx;
        logic [5:0]  vy;
        logic [5:0]  vz;
        logic        last;
    } voxel_t;

    class stencil_scoreboard;
        logic [31:0] old_ring[WIN_DEPTH];
        logic [31:0] src_ring[SRC_DEPTH];
        int unsigned in_cnt, out_cnt;
        int unsigned sx, sy, sz;
        logic [31:0] alpha, inv_beta;
        voxel_t expected_voxels[$];
        int errors;

        function new();
            in_cnt = 0;
            out_cnt = 0;
            sx = 1;
            sy = 1;
            sz = 1;
            alpha = ALPHA_RST;
            inv_beta = INV_BETA_RST;
            errors = 0;
        endfunction

        function int unsigned fit_size(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_SIZE_X:   sx = fit_size(32'(val[8:0]), MAX_X_DEF);
                REG_SIZE_Y:   sy = fit_size(32'(val[6:0]), MAX_Y_DEF);
                REG_SIZE_Z:   sz = fit_size(32'(val[6:0]), MAX_Z_DEF);
                REG_ALPHA:    alpha = val;
                REG_INV_BETA: inv_beta = val;
                default: ;
            endcase
            if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z) begin
                in_cnt = 0;
                out_cnt = 0;
            end
        endfunction

        function longint tap(int unsigned idx);
            return longint'($signed(old_ring[idx % WIN_DEPTH]));
        endfunction

        function void note_input(logic [31:0] ov, logic [31:0] srcv, logic flush);
            int unsigned plane, total, n, m, x, y, z, r;
            longint sum, fb;
            logic signed [95:0] prod;
            voxel_t v;
            plane = sy * sz;
            total = sx * plane;
            n = in_cnt;
            if (n < total) begin
                if (flush) return;
                old_ring[n % WIN_DEPTH] = ov;
                src_ring[n % SRC_DEPTH] = srcv;
            end
            in_cnt = n + 1;
            if (n < plane) return;
            m = out_cnt;
            x = m / plane;
            r = m % plane;
            y = r / sz;
            z = r % sz;
            sum = tap(x + 1 < sx ? m + plane : m) + tap(x > 0 ? m - plane : m)
                + tap(y + 1 < sy ? m + sz : m) + tap(y > 0 ? m - sz : m)
                + tap(z + 1 < sz ? m + 1 : m) + tap(z > 0 ? m - 1 : m);
            fb = (longint'($signed(alpha)) * longint'($signed(src_ring[m % SRC_DEPTH])))
                 >>> 16;
            prod = 96'(sum + fb);
            prod = (prod * $signed(inv_beta)) >>> 16;
            if (prod > 96'sd2147483647) v.new_value = 32'h7fffffff;
            else if (prod < -96'sd2147483648) v.new_value = 32'h80000000;
            else v.new_value = prod[31:0];
            v.vx = x[7:0];
            v.vy = y[5:0];
            v.vz = z[5:0];
            v.last = (m + 1 == total);
            expected_voxels.push_back(v);
            out_cnt = m + 1;
            if (out_cnt >= total) begin
                in_cnt = 0;
                out_cnt = 0;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic tl);
            voxel_t v;
            if (expected_voxels.size() == 0) begin
                report("unexpected transfer", data[31:0], 32'h0);
                return;
            end
            v = expected_voxels.pop_front();
            if (data[31:0] !== v.new_value) report("new_value", data[31:0], v.new_value);
            if (data[39:32] !== v.vx) report("out_x", 32'(data[39:32]), 32'(v.vx));
            if (data[45:40] !== v.vy) report("out_y", 32'(data[45:40]), 32'(v.vy));
            if (data[51:46] !== v.vz) report("out_z", 32'(data[51:46]), 32'(v.vz));
            if (tl !== v.last) report("last", 32'(tl), 32'(v.last));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stencil_scoreboard sb = new();
    int cycles = 0;
    int items_sent = 0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    jacobi_stencil_sweep_3d_core dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : receiver
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            sb.check_result(m_tdata, m_tlast);
        end
    end

    function logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            3: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    task send_item(logic [31:0] ov, logic [31:0] srcv, logic flush);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {srcv, ov};
        s_tuser <= flush;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(ov, srcv, flush);
        items_sent++;
        @(negedge aclk);
    endtask

    task settle();
        s_tvalid <= 1'b0;
        while (sb.expected_voxels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task sweep();
        int unsigned total, plane;
        total = sb.sx * sb.sy * sb.sz;
        plane = sb.sy * sb.sz;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item($urandom(), $urandom(), 1'b1);
            send_item(pick_value(), pick_value(), 1'b0);
        end
        for (int unsigned i = 0; i < plane; i++)
            send_item($urandom(), $urandom(), 1'($urandom_range(0, 1)));
        settle();
    endtask

    task setup(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
               logic [31:0] a, logic [31:0] ib);
        write_reg(REG_SIZE_X, nx);
        write_reg(REG_SIZE_Y, ny);
        write_reg(REG_SIZE_Z, nz);
        write_reg(REG_ALPHA, a);
        write_reg(REG_INV_BETA, ib);
        calm = ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sweep();
        setup(0, 0, 0, 32'h7fffffff, 32'h7fffffff);
        write_reg(REG_UNUSED, $urandom());
        sweep();
        setup(511, 1, 1, 32'h80000000, 32'h80000000);
        sweep();
        setup(2, 127, 1, 32'h00010000, 32'h00002aab);
        hold_request = 1'b1;
        sweep();
        setup(2, 1, 127, 32'hffff0000, 32'h0);
        sweep();

        while (items_sent < ITEM_GOAL) begin
            setup($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 5),
                  pick_value(), $urandom_range(0, 2) == 0 ? pick_value()
                                : 32'($urandom_range(0, 20000)));
            sweep();
        end

        settle();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
